[hw/rtl/mfsb_pkg.sv]
// Shared types and codes for the multilevel free-space bitmap.
package mfsb_pkg;

	typedef enum logic [1:0] {
		OP_FIND    = 2'd0,
		OP_UPGRADE = 2'd1,
		OP_DOWN    = 2'd2,
		OP_GROW    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BADLVL  = 2'd1,
		ST_BOUND   = 2'd2,
		ST_NOINIT  = 2'd3
	} status_t;

	localparam int unsigned SEQ_W  = 32;
	localparam int unsigned SIZE_W = 13;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;
		logic load;
		logic decode;
		logic lvl_step;
		logic mem_rd;
		logic tgt;
		logic find_chk;
		logic mod_step;
		logic bound_chk;
		logic up_chk;
		logic tgt_chk;
		logic finish;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic pv_bad;
		logic is_grow;
		logic lvl_bad;
		logic is_find;
		logic cur_end;
		logic cur_tgt;
		logic cnt_zero;
		logic word_end;
		logic hit;
		logic mod_last;
		logic oob;
		logic out_free;
	} dp_stat_t;

endpackage

[hw/rtl/mfsb_ctrl.sv]
// Controller state machine of the multilevel free-space bitmap.
module mfsb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mfsb_pkg::dp_stat_t   st,
	output mfsb_pkg::ctl_cmd_t   cmd
);

	typedef enum logic [13:0] {
		S_CLEAR  = 14'b00000000000001,
		S_IDLE   = 14'b00000000000010,
		S_DECODE = 14'b00000000000100,
		S_FLVL   = 14'b00000000001000,
		S_FRD    = 14'b00000000010000,
		S_FCHK   = 14'b00000000100000,
		S_MOD    = 14'b00000001000000,
		S_BOUND  = 14'b00000010000000,
		S_URD    = 14'b00000100000000,
		S_UCHK   = 14'b00001000000000,
		S_TCHK   = 14'b00010000000000,
		S_DONE   = 14'b00100000000000,
		S_SPARE1 = 14'b01000000000000,
		S_SPARE2 = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				if (st.pv_bad || st.is_grow || st.lvl_bad) begin
					state_d = S_DONE;
				end else if (st.is_find) begin
					state_d = S_FLVL;
				end else begin
					state_d = S_MOD;
				end
			end
			S_FLVL: begin
				if (st.cur_end) begin
					state_d = S_DONE;
				end else if (st.cnt_zero) begin
					cmd.lvl_step = 1'b1;
				end else begin
					state_d = S_FRD;
				end
			end
			S_FRD: begin
				if (st.word_end) begin
					cmd.lvl_step = 1'b1;
					state_d      = S_FLVL;
				end else begin
					cmd.mem_rd = 1'b1;
					state_d    = S_FCHK;
				end
			end
			S_FCHK: begin
				cmd.find_chk = 1'b1;
				state_d      = st.hit ? S_DONE : S_FRD;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (st.mod_last) begin
					state_d = S_BOUND;
				end
			end
			S_BOUND: begin
				cmd.bound_chk = 1'b1;
				state_d       = st.oob ? S_DONE : S_URD;
			end
			S_URD: begin
				if (st.cur_end) begin
					cmd.mem_rd = 1'b1;
					cmd.tgt    = 1'b1;
					state_d    = S_TCHK;
				end else if (st.cur_tgt) begin
					cmd.lvl_step = 1'b1;
				end else begin
					cmd.mem_rd = 1'b1;
					state_d    = S_UCHK;
				end
			end
			S_UCHK: begin
				cmd.up_chk = 1'b1;
				state_d    = S_URD;
			end
			S_TCHK: begin
				cmd.tgt     = 1'b1;
				cmd.tgt_chk = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				cmd.tgt = 1'b1;
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/mfsb_dp.sv]
// Datapath of the multilevel free-space bitmap: bitmap memory, counts and result.
module mfsb_dp #(
	parameter int unsigned LEVELS   = 8,
	parameter int unsigned CAPACITY = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mfsb_pkg::ctl_cmd_t   cmd,
	output mfsb_pkg::dp_stat_t   st,
	input  logic [19:0]          page_number,
	input  logic                 page_valid,
	input  logic [1:0]           in_cmd,
	input  logic [3:0]           in_level,
	input  logic [31:0]          in_seq,
	input  logic [12:0]          in_size,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic                 found,
	output logic [31:0]          found_sequence,
	output logic [3:0]           found_level,
	output logic                 upgraded,
	output logic [12:0]          level_count
);

	localparam int unsigned WORDS = (CAPACITY + 63) / 64;
	localparam int unsigned DEPTH = LEVELS * WORDS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned WCW   = $clog2(WORDS + 1);
	localparam int unsigned OW    = $clog2(CAPACITY);
	localparam int unsigned LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int unsigned CNW   = $clog2(CAPACITY + 1);
	localparam int unsigned CW    = (WCW + 6 > 13) ? WCW + 6 : 13;
	// Reciprocal of the capacity for the offset reduction; the estimated quotient is
	// at most one below the true one, so a single compare and subtract finishes it.
	localparam int unsigned KS    = $clog2(CAPACITY) - 1;
	localparam logic [63:0] RECIP = (64'd1 << (31 + KS)) / 64'(CAPACITY);

	logic [63:0]        mem [DEPTH];
	logic [63:0]        rdata_q;
	logic [AW-1:0]      clr_q;
	logic [CNW-1:0]     counts_q [LEVELS];

	mfsb_pkg::op_t      op_q;
	logic [3:0]         lvl_q;
	logic [31:0]        seq_q;
	logic [12:0]        size_q;
	logic [12:0]        used_q;
	logic [31:0]        base_q;
	logic [4:0]         cur_q;
	logic [WCW-1:0]     word_q;
	logic [OW-1:0]      off_q;
	logic [4:0]         mcnt_q;
	logic [63:0]        prod_q;
	logic [31:0]        red_q;
	logic               cleared_q;
	logic               found_q;
	logic               upg_q;
	logic [OW-1:0]      foff_q;
	logic [3:0]         flvl_q;
	mfsb_pkg::status_t  status_q;

	logic               ov_q;
	logic [1:0]         o_status_q;
	logic               o_found_q;
	logic [31:0]        o_fseq_q;
	logic [3:0]         o_flvl_q;
	logic               o_upg_q;
	logic [12:0]        o_cnt_q;

	logic               lvl_ok;
	logic [LW-1:0]      lvl_idx, cur_idx, idx;
	logic [WW-1:0]      off_word, word_idx;
	logic [5:0]         off_bit;
	logic [AW-1:0]      addr;
	logic [CNW-1:0]     cnt_rd;
	logic [CW-1:0]      wstart, rem;
	logic [63:0]        masked;
	logic [5:0]         bp;
	logic               bitv;
	logic [31:0]        quo;
	logic               mem_we;
	logic [AW-1:0]      waddr;
	logic [63:0]        wdata;
	logic               cnt_we;
	logic [CNW-1:0]     cnt_wd;

	assign lvl_ok   = {1'b0, lvl_q} < 5'(LEVELS);
	assign lvl_idx  = lvl_q[LW-1:0];
	assign cur_idx  = cur_q[LW-1:0];
	assign idx      = cmd.tgt ? lvl_idx : cur_idx;
	assign off_word = WW'(off_q >> 6);
	assign off_bit  = 6'(off_q);
	assign word_idx = (op_q == mfsb_pkg::OP_FIND) ? word_q[WW-1:0] : off_word;
	assign addr     = AW'(AW'(idx) * AW'(WORDS)) + AW'(word_idx);
	assign cnt_rd   = counts_q[idx];
	assign wstart   = CW'({word_q, 6'b0});
	assign rem      = CW'(used_q) - wstart;
	assign bitv     = rdata_q[off_bit];
	assign quo      = 32'(prod_q >> (31 + KS));

	always_comb begin
		for (int j = 0; j < 64; j++) begin
			masked[j] = rdata_q[j] && (CW'(j) < rem);
		end
		bp = '0;
		for (int j = 63; j >= 0; j--) begin
			if (masked[j]) begin
				bp = 6'(j);
			end
		end
	end

	assign st.clr_last = (clr_q == AW'(DEPTH - 1));
	assign st.pv_bad   = !page_valid;
	assign st.is_grow  = (op_q == mfsb_pkg::OP_GROW);
	assign st.lvl_bad  = !lvl_ok;
	assign st.is_find  = (op_q == mfsb_pkg::OP_FIND);
	assign st.cur_end  = (cur_q == 5'(LEVELS));
	assign st.cur_tgt  = (cur_q == {1'b0, lvl_q});
	assign st.cnt_zero = (cnt_rd == '0);
	assign st.word_end = (wstart >= CW'(used_q));
	assign st.hit      = (masked != '0);
	assign st.mod_last = (mcnt_q == 5'd2);
	assign st.oob      = (CW'(used_q) <= CW'(off_q));
	assign st.out_free = !ov_q || !out_stall;

	// Memory write and count update selection.
	always_comb begin
		mem_we = 1'b0;
		waddr  = addr;
		wdata  = rdata_q;
		cnt_we = 1'b0;
		cnt_wd = cnt_rd;
		if (cmd.clr_step) begin
			mem_we = 1'b1;
			waddr  = clr_q;
			wdata  = '0;
		end else if (cmd.find_chk && st.hit) begin
			mem_we     = 1'b1;
			wdata[bp]  = 1'b0;
			cnt_we     = (cnt_rd != '0);
			cnt_wd     = cnt_rd - 1'b1;
		end else if (cmd.up_chk && bitv) begin
			mem_we         = 1'b1;
			wdata[off_bit] = 1'b0;
			cnt_we         = (cnt_rd != '0);
			cnt_wd         = cnt_rd - 1'b1;
		end else if (cmd.tgt_chk) begin
			if (op_q == mfsb_pkg::OP_UPGRADE) begin
				if (!bitv) begin
					mem_we         = 1'b1;
					wdata[off_bit] = 1'b1;
					cnt_we         = 1'b1;
					cnt_wd         = cnt_rd + 1'b1;
				end
			end else if (cleared_q && bitv) begin
				mem_we         = 1'b1;
				wdata[off_bit] = 1'b0;
				cnt_we         = (cnt_rd != '0);
				cnt_wd         = cnt_rd - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.mem_rd) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			used_q <= '0;
			ov_q   <= 1'b0;
			for (int i = 0; i < LEVELS; i++) begin
				counts_q[i] <= '0;
			end
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cnt_we) begin
				counts_q[idx] <= cnt_wd;
			end
			if (cmd.decode && page_valid && op_q == mfsb_pkg::OP_GROW &&
			    CW'(size_q) <= CW'(CAPACITY) && used_q < size_q) begin
				used_q <= size_q;
			end
			if (cmd.finish) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= mfsb_pkg::op_t'(in_cmd);
			lvl_q     <= in_level;
			seq_q     <= in_seq;
			size_q    <= in_size;
			base_q    <= 32'(page_number) * 32'(CAPACITY);
			off_q     <= '0;
			mcnt_q    <= '0;
			cleared_q <= 1'b0;
			found_q   <= 1'b0;
			upg_q     <= 1'b0;
			foff_q    <= '0;
			flvl_q    <= '0;
		end
		if (cmd.decode) begin
			word_q <= '0;
			cur_q  <= (op_q == mfsb_pkg::OP_FIND) ? {1'b0, lvl_q} : 5'd0;
			if (!page_valid) begin
				status_q <= mfsb_pkg::ST_NOINIT;
			end else if (op_q == mfsb_pkg::OP_GROW) begin
				status_q <= (CW'(size_q) > CW'(CAPACITY)) ? mfsb_pkg::ST_BOUND
				                                          : mfsb_pkg::ST_OK;
			end else if (!lvl_ok) begin
				status_q <= mfsb_pkg::ST_BADLVL;
			end else begin
				status_q <= mfsb_pkg::ST_OK;
			end
		end
		if (cmd.lvl_step) begin
			cur_q  <= cur_q + 1'b1;
			word_q <= '0;
		end
		if (cmd.find_chk) begin
			if (st.hit) begin
				found_q <= 1'b1;
				foff_q  <= OW'({word_q, 6'b0}) + OW'(bp);
				flvl_q  <= 4'(cur_q);
			end else begin
				word_q <= word_q + 1'b1;
			end
		end
		// Offset reduction: multiply by the reciprocal, subtract the estimated
		// multiple of the capacity, then correct by at most one capacity.
		if (cmd.mod_step) begin
			if (mcnt_q == 5'd0) begin
				prod_q <= 64'(seq_q) * 64'(RECIP[31:0]);
			end else if (mcnt_q == 5'd1) begin
				red_q <= seq_q - quo * 32'(CAPACITY);
			end else begin
				off_q <= (red_q >= 32'(CAPACITY)) ? OW'(red_q - 32'(CAPACITY))
				                                  : OW'(red_q);
			end
			mcnt_q <= mcnt_q + 1'b1;
		end
		if (cmd.bound_chk && st.oob) begin
			status_q <= mfsb_pkg::ST_BOUND;
		end
		if (cmd.up_chk) begin
			cur_q <= cur_q + 1'b1;
			if (bitv) begin
				cleared_q <= 1'b1;
			end
		end
		if (cmd.tgt_chk && op_q == mfsb_pkg::OP_UPGRADE && !bitv) begin
			upg_q <= 1'b1;
		end
		if (cmd.finish) begin
			o_status_q <= status_q;
			o_found_q  <= found_q;
			o_fseq_q   <= found_q ? base_q + 32'(foff_q) : 32'd0;
			o_flvl_q   <= flvl_q;
			o_upg_q    <= upg_q;
			o_cnt_q    <= lvl_ok ? 13'(cnt_rd) : 13'd0;
		end
	end

	assign out_valid      = ov_q;
	assign status         = o_status_q;
	assign found          = o_found_q;
	assign found_sequence = o_fseq_q;
	assign found_level    = o_flvl_q;
	assign upgraded       = o_upg_q;
	assign level_count    = o_cnt_q;

`ifndef ASSERT_OFF
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && found_q |-> status_q == mfsb_pkg::ST_OK)
		else $error("found result with non-ok status");
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.find_chk && st.hit |-> cnt_rd != '0)
		else $error("set bit found in a level whose count is zero");
	a_used_cap: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(used_q) <= CW'(CAPACITY))
		else $error("used size above capacity");
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> ov_q)
		else $error("finished request not presented");
`endif

endmodule

[hw/rtl/multilevel_free_space_bitmap.sv]
// Top level of the multilevel free-space bitmap: configuration registers and wiring.
// Grow, invalid and uninitialized requests are decoded and answered without touching the bitmap.
// Upgrade and downgrade run an offset reduction and a bound check, then read and check the page bit in each level.
// Find checks each level's count from the requested level up, then reads and scans the words of a level with pages.
// Throughput: one request at a time through the single-port bitmap memory.
// After reset every word of the bitmap memory is cleared before requests are accepted.
module multilevel_free_space_bitmap #(
	parameter int unsigned LEVELS   = 8,
	parameter int unsigned CAPACITY = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [3:0]  level,
	input  logic [31:0] page_sequence,
	input  logic [12:0] new_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        found,
	output logic [31:0] found_sequence,
	output logic [3:0]  found_level,
	output logic        upgraded,
	output logic [12:0] level_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [19:0] cfg_data
);

	// The user must write the configuration registers only while no request is in flight; the block does not enforce it.
	logic [19:0] page_number_q;
	logic        page_valid_q;

	mfsb_pkg::ctl_cmd_t ctl;
	mfsb_pkg::dp_stat_t dst;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_number_q <= '0;
			page_valid_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			// Index zero is the page number; index one is the valid flag.
			if (cfg_index) begin
				page_valid_q <= cfg_data[0];
			end else begin
				page_number_q <= cfg_data;
			end
		end
	end

	// The controller sequences each request; the datapath holds all storage.
	mfsb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (dst),
		.cmd      (ctl)
	);

	mfsb_dp #(
		.LEVELS   (LEVELS),
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (ctl),
		.st             (dst),
		.page_number    (page_number_q),
		.page_valid     (page_valid_q),
		.in_cmd         (cmd),
		.in_level       (level),
		.in_seq         (page_sequence),
		.in_size        (new_size),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.found          (found),
		.found_sequence (found_sequence),
		.found_level    (found_level),
		.upgraded       (upgraded),
		.level_count    (level_count)
	);

endmodule

[test/multilevel_free_space_bitmap_test.sv]
// Self-checking testbench for the multilevel free-space bitmap block.
module multilevel_free_space_bitmap_test;

	localparam int unsigned NUM_LEVELS = 8;
	localparam int unsigned PAGES      = 4096;
	localparam int unsigned WORDS      = PAGES / 64;
	localparam int unsigned WATCHDOG   = 200000;

	// Register indexes of the configuration port.
	localparam logic REG_PAGE_NUMBER = 1'b0;
	localparam logic REG_PAGE_VALID  = 1'b1;

	typedef struct packed {
		mfsb_pkg::status_t status;
		logic        found;
		logic [31:0] found_sequence;
		logic [3:0]  found_level;
		logic        upgraded;
		logic [12:0] level_count;
	} alloc_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [3:0]  level;
	logic [31:0] page_sequence;
	logic [12:0] new_size;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic        found;
	logic [31:0] found_sequence;
	logic [3:0]  found_level;
	logic        upgraded;
	logic [12:0] level_count;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [19:0] cfg_data;

	multilevel_free_space_bitmap u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .level(level), .page_sequence(page_sequence), .new_size(new_size),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .found(found), .found_sequence(found_sequence),
		.found_level(found_level), .upgraded(upgraded), .level_count(level_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the free-space map, kept in step with every accepted request.
	logic [63:0] shadow_map [NUM_LEVELS][WORDS];
	logic [12:0] shadow_count [NUM_LEVELS];
	logic [12:0] shadow_used;
	logic [19:0] shadow_page_number;
	logic        shadow_page_valid;

	alloc_result_t pending_results[$];
	int            errors;
	int            sent_count;
	int            checked_count;
	int            idle_cycles;
	int            find_hits;
	int            upgrades_seen;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The watchdog counts cycles in which no request, result or register write moves.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("t=%0t watchdog expired with %0d results outstanding", $time,
				pending_results.size());
			$display("multilevel_free_space_bitmap regression: fail");
			$finish;
		end
	end

	function automatic void clear_shadow();
		for (int l = 0; l < NUM_LEVELS; l++) begin
			shadow_count[l] = '0;
			for (int w = 0; w < WORDS; w++)
				shadow_map[l][w] = '0;
		end
		shadow_used = '0;
		shadow_page_number = '0;
		shadow_page_valid = 1'b0;
	endfunction

	// Clears one page from one level; returns 1 when the page was held there.
	function automatic bit take_page(int l, int off);
		if (!shadow_map[l][off / 64][off % 64])
			return 1'b0;
		shadow_map[l][off / 64][off % 64] = 1'b0;
		if (shadow_count[l] != 0)
			shadow_count[l]--;
		return 1'b1;
	endfunction

	// Computes the result of one request and advances the shadow map.
	function automatic alloc_result_t predict_allocation(mfsb_pkg::op_t op, logic [3:0] lvl,
			logic [31:0] seq, logic [12:0] size);
		alloc_result_t r;
		bit lvl_ok;
		int off;
		int cleared;
		r = '0;
		r.status = mfsb_pkg::ST_OK;
		lvl_ok = lvl < NUM_LEVELS;
		if (!shadow_page_valid) begin
			r.status = mfsb_pkg::ST_NOINIT;
		end else if (op == mfsb_pkg::OP_GROW) begin
			if (size > PAGES)
				r.status = mfsb_pkg::ST_BOUND;
			else if (shadow_used < size)
				shadow_used = size;
		end else if (!lvl_ok) begin
			r.status = mfsb_pkg::ST_BADLVL;
		end else if (op == mfsb_pkg::OP_FIND) begin
			for (int l = lvl; l < NUM_LEVELS && !r.found; l++) begin
				if (shadow_count[l] == 0)
					continue;
				for (int o = 0; o < shadow_used && o < PAGES; o++) begin
					if (shadow_map[l][o / 64][o % 64]) begin
						void'(take_page(l, o));
						r.found = 1'b1;
						r.found_sequence = 32'(shadow_page_number) * PAGES + o;
						r.found_level = 4'(l);
						break;
					end
				end
			end
		end else begin
			off = seq % PAGES;
			cleared = 0;
			if (shadow_used <= off) begin
				r.status = mfsb_pkg::ST_BOUND;
			end else begin
				for (int l = 0; l < NUM_LEVELS; l++)
					if (l != lvl && take_page(l, off))
						cleared++;
				if (op == mfsb_pkg::OP_UPGRADE) begin
					if (!shadow_map[lvl][off / 64][off % 64]) begin
						shadow_map[lvl][off / 64][off % 64] = 1'b1;
						shadow_count[lvl]++;
						r.upgraded = 1'b1;
					end
				end else if (cleared != 0) begin
					void'(take_page(lvl, off));
				end
			end
		end
		r.level_count = lvl_ok ? shadow_count[lvl] : '0;
		return r;
	endfunction

	// Result side: random stalls, and each accepted result is checked against the oldest
	// expectation.
	initial begin
		alloc_result_t want;
		alloc_result_t got;
		int wait_cycles;
		out_stall <= 1'b1;
		@(posedge arst_n);
		forever begin
			wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			if (wait_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got = {mfsb_pkg::status_t'(status), found, found_sequence, found_level, upgraded,
				level_count};
			if (pending_results.size() == 0) begin
				$display("t=%0t unexpected result %h", $time, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (got.found && want.found) find_hits++;
				if (got.upgraded && want.upgraded) upgrades_seen++;
				if (got.status !== want.status) begin
					$display("t=%0t status expected %0d actual %0d", $time, want.status,
						got.status);
					errors++;
				end
				if (got.found !== want.found) begin
					$display("t=%0t found expected %0d actual %0d", $time, want.found,
						got.found);
					errors++;
				end
				if (got.found_sequence !== want.found_sequence) begin
					$display("t=%0t found_sequence expected %h actual %h", $time,
						want.found_sequence, got.found_sequence);
					errors++;
				end
				if (got.found_level !== want.found_level) begin
					$display("t=%0t found_level expected %0d actual %0d", $time,
						want.found_level, got.found_level);
					errors++;
				end
				if (got.upgraded !== want.upgraded) begin
					$display("t=%0t upgraded expected %0d actual %0d", $time,
						want.upgraded, got.upgraded);
					errors++;
				end
				if (got.level_count !== want.level_count) begin
					$display("t=%0t level_count expected %0d actual %0d", $time,
						want.level_count, got.level_count);
					errors++;
				end
			end
		end
	end

	// Sends one request after a random gap; the prediction is made once it is accepted.
	// Valid is dropped at the start of a gap or by the drain task.
	task automatic send_request(mfsb_pkg::op_t op, logic [3:0] lvl, logic [31:0] seq,
			logic [12:0] size);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		level <= lvl;
		page_sequence <= seq;
		new_size <= size;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(predict_allocation(op, lvl, seq, size));
		sent_count++;
	endtask

	// Waits until every expected result has arrived, then lets the block settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_register(logic idx, logic [19:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_PAGE_NUMBER)
			shadow_page_number = value;
		else
			shadow_page_valid = value[0];
		@(posedge clk);
	endtask

	// Offsets are kept below the used size most of the time, with a global sequence whose
	// upper bits are random so the modulo reduction is exercised.
	function automatic logic [31:0] pick_sequence();
		logic [31:0] s;
		s = $urandom;
		if ($urandom_range(0, 9) != 0 && shadow_used != 0)
			s[11:0] = 12'($urandom_range(0, shadow_used - 1));
		return s;
	endfunction

	function automatic logic [3:0] pick_level();
		return ($urandom_range(0, 15) == 0) ? 4'($urandom_range(NUM_LEVELS, 15))
			: 4'($urandom_range(0, NUM_LEVELS - 1));
	endfunction

	// Every command is refused while the page is not marked valid.
	task automatic test_uninitialized();
		send_request(mfsb_pkg::OP_FIND, 4'd0, 32'd0, 13'd0);
		send_request(mfsb_pkg::OP_UPGRADE, 4'd15, 32'hFFFF_FFFF, 13'h1FFF);
		send_request(mfsb_pkg::OP_DOWN, 4'd3, 32'd5, 13'd0);
		send_request(mfsb_pkg::OP_GROW, 4'd0, 32'd0, 13'd100);
		drain_results();
	endtask

	// Directed corners: empty map, bound checks, invalid levels, downgrade with no other
	// level, and the size extremes.
	task automatic test_directed();
		write_register(REG_PAGE_NUMBER, 20'hFFFFF);
		write_register(REG_PAGE_VALID, 20'd1);
		send_request(mfsb_pkg::OP_FIND, 4'd0, 32'd0, 13'd0);
		send_request(mfsb_pkg::OP_UPGRADE, 4'd0, 32'd0, 13'd0);
		send_request(mfsb_pkg::OP_GROW, 4'd9, 32'd0, 13'd4097);
		send_request(mfsb_pkg::OP_GROW, 4'd15, 32'hFFFF_FFFF, 13'h1FFF);
		send_request(mfsb_pkg::OP_GROW, 4'd0, 32'd0, 13'd64);
		send_request(mfsb_pkg::OP_GROW, 4'd0, 32'd0, 13'd10);
		send_request(mfsb_pkg::OP_UPGRADE, 4'd8, 32'd3, 13'd0);
		send_request(mfsb_pkg::OP_UPGRADE, 4'd7, 32'h1234_5003, 13'd0);
		send_request(mfsb_pkg::OP_UPGRADE, 4'd7, 32'd3, 13'd0);
		send_request(mfsb_pkg::OP_UPGRADE, 4'd2, 32'd63, 13'd0);
		send_request(mfsb_pkg::OP_DOWN, 4'd5, 32'd40, 13'd0);
		send_request(mfsb_pkg::OP_DOWN, 4'd7, 32'd63, 13'd0);
		send_request(mfsb_pkg::OP_FIND, 4'd15, 32'd0, 13'd0);
		send_request(mfsb_pkg::OP_FIND, 4'd0, 32'd0, 13'd0);
		send_request(mfsb_pkg::OP_FIND, 4'd0, 32'd0, 13'd0);
		send_request(mfsb_pkg::OP_GROW, 4'd0, 32'd0, 13'd4096);
		send_request(mfsb_pkg::OP_UPGRADE, 4'd0, 32'hFFFF_FFFF, 13'd0);
		send_request(mfsb_pkg::OP_UPGRADE, 4'd1, 32'd100, 13'd0);
		send_request(mfsb_pkg::OP_FIND, 4'd0, 32'd0, 13'd0);
		send_request(mfsb_pkg::OP_DOWN, 4'd1, 32'd4095, 13'd0);
		send_request(mfsb_pkg::OP_FIND, 4'd0, 32'd0, 13'd0);
		drain_results();
	endtask

	// Random traffic: mostly upgrades and finds on a map that grows gradually.
	task automatic test_random(int count, logic [19:0] page_num);
		mfsb_pkg::op_t op;
		int pick;
		write_register(REG_PAGE_NUMBER, page_num);
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) op = mfsb_pkg::OP_UPGRADE;
			else if (pick < 70) op = mfsb_pkg::OP_FIND;
			else if (pick < 90) op = mfsb_pkg::OP_DOWN;
			else op = mfsb_pkg::OP_GROW;
			send_request(op, pick_level(), pick_sequence(),
				($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(0, 400)));
			// Hold the sender back once so the block goes fully idle mid-stream.
			if (n == count / 2)
				drain_results();
		end
		drain_results();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= '0;
		level <= '0;
		page_sequence <= '0;
		new_size <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_PAGE_NUMBER;
		cfg_data <= '0;
		errors = 0;
		sent_count = 0;
		checked_count = 0;
		idle_cycles = 0;
		find_hits = 0;
		upgrades_seen = 0;
		clear_shadow();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_uninitialized();
		test_directed();
		test_random(500, 20'd0);
		test_random(450, 20'd12345);
		test_random(450, 20'hFFFFF);
		write_register(REG_PAGE_VALID, 20'd0);
		test_uninitialized();
		repeat (50) @(posedge clk);

		$display("Sent %0d requests over three page numbers; %0d results checked.",
			sent_count, checked_count);
		$display("Finds that located a page: %0d; upgrades that set a page: %0d.",
			find_hits, upgrades_seen);
		if (errors == 0 && pending_results.size() == 0)
			$display("multilevel_free_space_bitmap regression: pass");
		else
			$display("multilevel_free_space_bitmap regression: fail");
		$finish;
	end

endmodule
